[hdl/lprts_pkg.sv]
package lprts_pkg;

    localparam int NUM_SLOTS  = 1024;
    localparam int PAGE_BYTES = 8192;

    localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int POS_W      = 64;
    localparam int LEN_W      = 14;
    localparam int SLOT_IDX_W = 10;

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [POS_W-1:0]     pos_t;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_TRIM   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_CLAIM  = 2'd1,
        OUT_BYPASS = 2'd2,
        OUT_DONE   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        pos_t range_start;
        pos_t range_end;
    } entry_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t data;
    } ram_wr_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
    } ram_rd_t;

    typedef struct packed {
        outcome_t               outcome;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic                   slot_valid;
        logic                   applied;
    } rsp_t;

endpackage

[hdl/lprts_if.sv]
interface lprts_req_if;
    import lprts_pkg::*;

    logic                 valid;
    logic                 ready;
    cmd_t                 command;
    logic [POS_W-1:0]     log_position;
    logic [LEN_W-1:0]     length;
    logic                 evict_enable;

    modport source (output valid, command, log_position, length, evict_enable,
                    input ready);
    modport sink   (input valid, command, log_position, length, evict_enable,
                    output ready);
endinterface

interface lprts_rsp_if;
    import lprts_pkg::*;

    logic                  valid;
    logic                  ready;
    outcome_t              outcome;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  slot_valid;
    logic                  applied;

    modport source (output valid, outcome, slot_index, slot_valid, applied,
                    input ready);
    modport sink   (input valid, outcome, slot_index, slot_valid, applied,
                    output ready);
endinterface

[hdl/lprts_tag_ram.sv]
module lprts_tag_ram
    import lprts_pkg::*;
(
    input  logic    clk,
    input  ram_wr_t wr,
    input  ram_rd_t rd,
    output entry_t  rd_data
);

    entry_t tag_mem [NUM_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= tag_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/lprts_engine.sv]
module lprts_engine
    import lprts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lprts_req_if.sink     req,
    input  logic          out_free,
    input  entry_t        rd_data,
    output ram_wr_t       wr,
    output ram_rd_t       rd,
    output logic          res_load,
    output rsp_t          res
);

    state_t state_reg, state_next;
    slot_t  clr_addr_reg, clr_addr_next;

    cmd_t   cmd_reg;
    pos_t   pos_reg;
    pos_t   last_reg;
    logic   evict_reg;
    slot_t  slot_reg;

    logic   accept;
    logic   clr_done;
    pos_t   base;
    logic   eval_write;
    entry_t eval_data;
    rsp_t   eval_res;

    assign accept   = req.valid && req.ready;
    assign clr_done = (clr_addr_reg == slot_t'(NUM_SLOTS - 1));
    assign base     = {pos_reg[POS_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    // next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + slot_t'(1);
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // capture the transaction; the last byte is formed here, modulo 2^64
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            pos_reg   <= req.log_position;
            last_reg  <= req.log_position + POS_W'(req.length) - POS_W'(1);
            evict_reg <= req.evict_enable;
            slot_reg  <= req.log_position[PAGE_SHIFT +: SLOT_BITS];
        end
    end

    // evaluate the stored slot against the held transaction
    always_comb
    begin
        eval_write = 1'b0;
        eval_data  = rd_data;
        eval_res   = '{outcome: OUT_DONE, slot_index: '0, slot_valid: 1'b0,
                       applied: 1'b0};
        case (cmd_reg)
            CMD_LOOKUP:
            begin
                if (rd_data.range_start == pos_reg && rd_data.range_end >= last_reg)
                begin
                    eval_res.outcome    = OUT_HIT;
                    eval_res.slot_index = SLOT_IDX_W'(slot_reg);
                    eval_res.slot_valid = 1'b1;
                end
                else if (evict_reg && rd_data.range_end < last_reg)
                begin
                    eval_write          = 1'b1;
                    eval_data           = '{range_start: pos_reg, range_end: last_reg};
                    eval_res.outcome    = OUT_CLAIM;
                    eval_res.slot_index = SLOT_IDX_W'(slot_reg);
                    eval_res.slot_valid = 1'b1;
                end
                else
                begin
                    eval_res.outcome = OUT_BYPASS;
                end
            end
            CMD_TRIM:
            begin
                if (rd_data.range_start == base && rd_data.range_end > pos_reg)
                begin
                    eval_write          = 1'b1;
                    eval_data.range_end = pos_reg;
                    eval_res.applied    = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (rd_data.range_start == base)
                begin
                    eval_write       = 1'b1;
                    eval_data        = '0;
                    eval_res.applied = 1'b1;
                end
            end
            default:
            begin
                eval_write = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready = 1'b0;
        rd        = '{en: 1'b0, addr: req.log_position[PAGE_SHIFT +: SLOT_BITS]};
        wr        = '{en: 1'b0, addr: slot_reg, data: eval_data};
        res_load  = 1'b0;
        res       = eval_res;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr = '{en: 1'b1, addr: clr_addr_reg, data: '0};
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                rd.en     = req.valid;
            end
            ST_EVAL:
            begin
                res_load = out_free;
                wr.en    = out_free && eval_write;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

endmodule

[hdl/log_page_range_tag_store_top.sv]
// Direct-mapped tag store for log pages. Each of 1024 slots holds the start
// and end log position of a cached page; the slot of a position is
// (position / 8192) mod 1024. Command 0 looks a range up and, on a miss with
// evict_enable set and the slot falling short, claims the slot; command 1
// trims a matching page's end down to the position; command 2 removes a
// matching page. Every request transaction yields exactly one response
// transaction. After reset the block sweeps all 1024 slots to zero, one per
// cycle, and accepts no request during the sweep. After that each request
// passes through the synchronous read of the slot memory, then the compare,
// slot write-back and response register load; a new request is not taken
// until the previous one has left evaluation. The response register lets a new
// request be read while the previous response still waits on rsp.ready; a
// request whose response cannot be loaded holds in evaluation until the
// register drains.
module log_page_range_tag_store_top
    import lprts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lprts_req_if.sink    req,
    lprts_rsp_if.source  rsp
);

    ram_wr_t wr;
    ram_rd_t rd;
    entry_t  rd_data;
    logic    out_free;
    logic    res_load;
    rsp_t    res;

    logic    out_valid_reg, out_valid_next;
    rsp_t    out_data_reg;

    // slot memory: start and end of each page in one word
    lprts_tag_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // request sequencing, slot evaluation and the clearing sweep
    lprts_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .rd_data  (rd_data),
        .wr       (wr),
        .rd       (rd),
        .res_load (res_load),
        .res      (res)
    );

    // response register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload until the response is taken
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.outcome    = out_data_reg.outcome;
    assign rsp.slot_index = out_data_reg.slot_index;
    assign rsp.slot_valid = out_data_reg.slot_valid;
    assign rsp.applied    = out_data_reg.applied;

    // one request in flight: no new request right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while previous one still in evaluation");

    // slot memory never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.en && rd.en))
        else $error("slot memory read and write overlap");

    // a response is loaded only into a free register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || rsp.ready))
        else $error("response register overwritten before it was taken");

endmodule
